>>> sv/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants, codes and field widths of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

	localparam int BLOCKS          = 64;
	localparam int MAX_FILE_BLOCKS = 32;
	localparam int ADDR_W          = $clog2(BLOCKS);

	localparam int SIZE_W   = 16;
	localparam int DVD_W    = SIZE_W + 1;
	localparam int CNT_W    = 16;
	localparam int LEFT_W   = 6;
	localparam int TOTAL_W  = 7;
	localparam int BLK_W    = 8;
	localparam int CMD_W    = 2;
	localparam int STAT_W   = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W    = 16;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 24;

	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CONTIG = 2'd1;
	localparam logic [CMD_W-1:0] CMD_OPEN   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_BLOCK  = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
	localparam logic [STAT_W-1:0] ST_REFUSED = 3'd1;
	localparam logic [STAT_W-1:0] ST_PENDING = 3'd2;
	localparam logic [STAT_W-1:0] ST_FAILED  = 3'd3;
	localparam logic [STAT_W-1:0] ST_INDEX   = 3'd4;
	localparam logic [STAT_W-1:0] ST_IGNORED = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL      = 1'd1;

	typedef struct packed {
		logic pend;
		logic used;
	} map_entry_t;

endpackage

>>> sv/block_bitmap_file_allocator_unit.sv
// ----------------------------------------------------------------------------
// block_bitmap_file_allocator_unit
// Used/pending bitmap in one synchronous memory with a control sequencer.
// ----------------------------------------------------------------------------
// One request at a time: a new request is taken only once the last result has
// been loaded into the output register. The last listed block of a file starts
// a commit sweep over all BLOCKS entries; contiguous and open requests run the
// divider first, and contiguous requests then check and mark blocks one by one;
// the divider and the single memory port pair limit the rate.
// Reset: a clearing pass over all BLOCKS entries runs first; no request is taken.
module block_bitmap_file_allocator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bfa_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// file_size[15:0], start_block[23:16], use_index[24],
	// index_block[32:25], block_number[40:33]
	input  logic [bfa_pkg::S_DATA_W-1:0] s_axis_tdata,
	// command[1:0]
	input  logic [bfa_pkg::CMD_W-1:0]    s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// block_count[15:0], blocks_left[21:16]
	output logic [bfa_pkg::M_DATA_W-1:0] m_axis_tdata,
	// status[2:0]
	output logic [bfa_pkg::STAT_W-1:0]   m_axis_tuser
);
	import bfa_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLR  = 4'd1;
	localparam logic [3:0] S_DIV  = 4'd2;
	localparam logic [3:0] S_CRD  = 4'd3;
	localparam logic [3:0] S_CEV  = 4'd4;
	localparam logic [3:0] S_MWR  = 4'd5;
	localparam logic [3:0] S_IRD  = 4'd6;
	localparam logic [3:0] S_IEV  = 4'd7;
	localparam logic [3:0] S_OPEN = 4'd8;
	localparam logic [3:0] S_LRD  = 4'd9;
	localparam logic [3:0] S_LEV  = 4'd10;
	localparam logic [3:0] S_LDEC = 4'd11;
	localparam logic [3:0] S_SRD  = 4'd12;
	localparam logic [3:0] S_SWR  = 4'd13;
	localparam logic [3:0] S_FIN  = 4'd14;

	logic [3:0]          state_q;
	logic [SIZE_W-1:0]   bsize_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [BLK_W-1:0]    start_q;
	logic                useidx_q;
	logic [BLK_W-1:0]    idx_q;
	logic [BLK_W-1:0]    bn_q;
	logic [DVD_W-1:0]    quo_q;
	logic [ADDR_W-1:0]   j_q;
	logic                clr_reply_q;
	logic                open_q;
	logic                failed_q;
	logic [LEFT_W-1:0]   rem_q;
	logic [ADDR_W-1:0]   held_q;
	logic                held_flag_q;
	logic [STAT_W-1:0]   res_stat_q;
	logic [CNT_W-1:0]    res_cnt_q;
	logic [LEFT_W-1:0]   res_left_q;
	logic                m_valid_q;
	logic [STAT_W-1:0]   m_stat_q;
	logic [CNT_W-1:0]    m_cnt_q;
	logic [LEFT_W-1:0]   m_left_q;

	map_entry_t          mem [BLOCKS];
	map_entry_t          rdata_q;
	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	map_entry_t          mem_wdata;
	logic [ADDR_W-1:0]   mem_raddr;

	logic [TOTAL_W-1:0]  usable;
	logic [SIZE_W-1:0]   bs_eff;
	logic [DVD_W-1:0]    dividend;
	logic                div_start;
	logic                div_done;
	logic [DVD_W-1:0]    div_q;
	logic [DVD_W:0]      span;
	logic                last_j;
	logic [LEFT_W-1:0]   rem_dec;
	logic                accept;
	logic                out_load;

	assign usable   = (total_q > TOTAL_W'(BLOCKS)) ? TOTAL_W'(BLOCKS) : total_q;
	assign bs_eff   = (bsize_q == '0) ? SIZE_W'(1) : bsize_q;
	assign dividend = {1'b0, s_axis_tdata[SIZE_W-1:0]} + {1'b0, bs_eff} - DVD_W'(1);
	assign span     = (DVD_W+1)'(start_q) + {1'b0, div_q};
	assign last_j   = {{(DVD_W-ADDR_W){1'b0}}, j_q} == (quo_q - DVD_W'(1));
	assign rem_dec  = rem_q - LEFT_W'(1);
	assign div_start = (state_q == S_IDLE) && accept && !open_q &&
		(s_axis_tuser == CMD_CONTIG || s_axis_tuser == CMD_OPEN);
	assign out_load = (state_q == S_FIN) && (!m_valid_q || m_axis_tready);

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(M_DATA_W-CNT_W-LEFT_W){1'b0}}, m_left_q, m_cnt_q};
	assign m_axis_tuser  = m_stat_q;

	bfa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (bs_eff),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = j_q;
		mem_wdata = '0;
		mem_raddr = j_q;
		case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
			end
			S_CRD: begin
				mem_raddr = ADDR_W'(start_q + BLK_W'(j_q));
			end
			S_MWR: begin
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(start_q + BLK_W'(j_q));
				mem_wdata = '{pend: 1'b0, used: 1'b1};
			end
			S_IRD: begin
				mem_raddr = idx_q[ADDR_W-1:0];
			end
			S_IEV: begin
				mem_we    = !rdata_q.used;
				mem_waddr = idx_q[ADDR_W-1:0];
				mem_wdata = '{pend: 1'b0, used: 1'b1};
			end
			S_LRD: begin
				mem_raddr = bn_q[ADDR_W-1:0];
			end
			S_LEV: begin
				mem_we    = !rdata_q.used;
				mem_waddr = bn_q[ADDR_W-1:0];
				mem_wdata = '{pend: 1'b1, used: 1'b0};
			end
			S_SWR: begin
				mem_we = 1'b1;
				if (failed_q)
					mem_wdata.used = rdata_q.used && !(held_flag_q && j_q == held_q);
				else
					mem_wdata.used = rdata_q.used || rdata_q.pend;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsize_q <= SIZE_W'(1);
			total_q <= TOTAL_W'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BLOCK_SIZE: bsize_q <= cfg_data;
				CFG_TOTAL:      total_q <= cfg_data[TOTAL_W-1:0];
				default:        bsize_q <= bsize_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= s_axis_tuser;
			start_q  <= s_axis_tdata[23:16];
			useidx_q <= s_axis_tdata[24];
			idx_q    <= s_axis_tdata[32:25];
			bn_q     <= s_axis_tdata[40:33];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			j_q         <= '0;
			clr_reply_q <= 1'b0;
			open_q      <= 1'b0;
			failed_q    <= 1'b0;
			rem_q       <= '0;
			held_q      <= '0;
			held_flag_q <= 1'b0;
			quo_q       <= '0;
			res_stat_q  <= ST_OK;
			res_cnt_q   <= '0;
			res_left_q  <= '0;
			m_valid_q   <= 1'b0;
			m_stat_q    <= ST_OK;
			m_cnt_q     <= '0;
			m_left_q    <= '0;
		end else begin
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_valid_q && m_axis_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_cnt_q  <= '0;
						res_left_q <= '0;
						j_q        <= '0;
						case (s_axis_tuser)
							CMD_CLEAR: begin
								clr_reply_q <= 1'b1;
								open_q      <= 1'b0;
								failed_q    <= 1'b0;
								rem_q       <= '0;
								held_q      <= '0;
								held_flag_q <= 1'b0;
								state_q     <= S_CLR;
							end
							CMD_BLOCK: begin
								if (!open_q) begin
									res_stat_q <= ST_IGNORED;
									state_q    <= S_FIN;
								end else if (failed_q) begin
									state_q <= S_LDEC;
								end else if ({1'b0, usable} > s_axis_tdata[40:33]) begin
									state_q <= S_LRD;
								end else begin
									failed_q <= 1'b1;
									state_q  <= S_LDEC;
								end
							end
							default: begin
								if (open_q) begin
									res_stat_q <= ST_IGNORED;
									res_left_q <= rem_q;
									state_q    <= S_FIN;
								end else begin
									state_q <= S_DIV;
								end
							end
						endcase
					end
				end
				S_CLR: begin
					j_q <= j_q + 1'b1;
					if (j_q == ADDR_W'(BLOCKS - 1)) begin
						j_q        <= '0;
						res_stat_q <= ST_OK;
						state_q    <= clr_reply_q ? S_FIN : S_IDLE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						quo_q     <= div_q;
						res_cnt_q <= div_q[CNT_W-1:0];
						if (cmd_q == CMD_CONTIG) begin
							if (span > (DVD_W+1)'(usable)) begin
								res_stat_q <= ST_REFUSED;
								state_q    <= S_FIN;
							end else if (div_q == '0) begin
								res_stat_q <= ST_OK;
								state_q    <= S_FIN;
							end else begin
								state_q <= S_CRD;
							end
						end else if (div_q > DVD_W'(MAX_FILE_BLOCKS)) begin
							res_stat_q <= ST_REFUSED;
							state_q    <= S_FIN;
						end else if (useidx_q) begin
							if ({1'b0, usable} > idx_q) begin
								state_q <= S_IRD;
							end else begin
								res_stat_q <= ST_INDEX;
								state_q    <= S_FIN;
							end
						end else begin
							state_q <= S_OPEN;
						end
					end
				end
				S_CRD: begin
					state_q <= S_CEV;
				end
				S_CEV: begin
					if (rdata_q.used) begin
						res_stat_q <= ST_REFUSED;
						state_q    <= S_FIN;
					end else if (last_j) begin
						j_q     <= '0;
						state_q <= S_MWR;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_CRD;
					end
				end
				S_MWR: begin
					j_q <= j_q + 1'b1;
					if (last_j) begin
						res_stat_q <= ST_OK;
						state_q    <= S_FIN;
					end
				end
				S_IRD: begin
					state_q <= S_IEV;
				end
				S_IEV: begin
					if (rdata_q.used) begin
						res_stat_q <= ST_INDEX;
						state_q    <= S_FIN;
					end else begin
						state_q <= S_OPEN;
					end
				end
				S_OPEN: begin
					if (quo_q == '0) begin
						res_stat_q <= ST_OK;
					end else begin
						open_q      <= 1'b1;
						failed_q    <= 1'b0;
						rem_q       <= quo_q[LEFT_W-1:0];
						held_flag_q <= useidx_q;
						held_q      <= useidx_q ? idx_q[ADDR_W-1:0] : '0;
						res_stat_q  <= ST_PENDING;
						res_left_q  <= quo_q[LEFT_W-1:0];
					end
					state_q <= S_FIN;
				end
				S_LRD: begin
					state_q <= S_LEV;
				end
				S_LEV: begin
					if (rdata_q.used)
						failed_q <= 1'b1;
					state_q <= S_LDEC;
				end
				S_LDEC: begin
					rem_q <= rem_dec;
					if (rem_dec != '0) begin
						res_stat_q <= failed_q ? ST_FAILED : ST_PENDING;
						res_left_q <= rem_dec;
						state_q    <= S_FIN;
					end else begin
						j_q     <= '0;
						state_q <= S_SRD;
					end
				end
				S_SRD: begin
					state_q <= S_SWR;
				end
				S_SWR: begin
					j_q     <= j_q + 1'b1;
					state_q <= S_SRD;
					if (j_q == ADDR_W'(BLOCKS - 1)) begin
						res_stat_q  <= failed_q ? ST_REFUSED : ST_OK;
						open_q      <= 1'b0;
						failed_q    <= 1'b0;
						held_q      <= '0;
						held_flag_q <= 1'b0;
						state_q     <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						m_stat_q <= res_stat_q;
						m_cnt_q  <= res_cnt_q;
						m_left_q <= res_left_q;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> sv/bfa_div.sv
// ----------------------------------------------------------------------------
// bfa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bfa_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bfa_pkg::DVD_W-1:0] dividend,
	input  logic [bfa_pkg::SIZE_W-1:0] divisor,
	output logic                      done,
	output logic [bfa_pkg::DVD_W-1:0] quotient
);
	import bfa_pkg::*;

	localparam int STEP_W = $clog2(DVD_W);

	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] dvs_q;
	logic [DVD_W-1:0]  n_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic              done_q;
	logic [SIZE_W:0]   trial;
	logic              ge;

	assign trial    = {rem_q, n_q[DVD_W-1]};
	assign ge       = trial >= {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DVD_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			n_q   <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? SIZE_W'(trial - {1'b0, dvs_q}) : trial[SIZE_W-1:0];
			n_q   <= {n_q[DVD_W-2:0], ge};
		end
	end

endmodule

>>> sv/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks of the bitmap block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfa_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cfg_we,
	input logic [bfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [bfa_pkg::CFG_W-1:0]    cfg_data,
	input logic                         s_axis_tvalid,
	input logic                         s_axis_tready,
	input logic [bfa_pkg::S_DATA_W-1:0] s_axis_tdata,
	input logic [bfa_pkg::CMD_W-1:0]    s_axis_tuser,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [bfa_pkg::M_DATA_W-1:0] m_axis_tdata,
	input logic [bfa_pkg::STAT_W-1:0]   m_axis_tuser
);
	import bfa_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while busy");

	a_pending_left: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_PENDING || m_axis_tuser == ST_FAILED)
		|-> m_axis_tdata[21:16] != '0)
		else $error("open file result with no blocks left");

	a_index_left: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_INDEX || m_axis_tuser == ST_REFUSED)
		|-> m_axis_tdata[21:16] == '0)
		else $error("refusal reports blocks left");

endmodule

bind block_bitmap_file_allocator_unit bfa_checker u_bfa_checker (.*);
